### rtl/wle_pkg.sv
// ----------------------------------------------------------------------------
// wle_pkg
// shared types and constants of the windowed level estimator
// ----------------------------------------------------------------------------
package wle_pkg;

    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 16;
    localparam int MODE_W      = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // estimation modes, the unused code behaves as last
    localparam logic [MODE_W-1:0] MODE_LAST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW = 2'd1;

    typedef struct packed {
        logic [TIME_W-1:0]         stamp;
        logic signed [LEVEL_W-1:0] level;
    } sample_t;

    typedef struct packed {
        logic take;  // take the neighbor's sample
        logic load;  // take the new sample
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_PRE,
        ST_ADD,
        ST_EXP_POST,
        ST_MIN,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

### rtl/wle_if.sv
// ----------------------------------------------------------------------------
// wle_if
// channel interfaces: input items, result items and register writes
// ----------------------------------------------------------------------------
interface wle_in_if
    import wle_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [TIME_W-1:0]         now_time;
    logic                      has_sample;
    logic signed [LEVEL_W-1:0] sample_level;

    modport source (output valid, now_time, has_sample, sample_level, input ready);
    modport sink   (input valid, now_time, has_sample, sample_level, output ready);
endinterface

interface wle_out_if
    import wle_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] estimate;
    logic                      estimate_valid;
    logic [COUNT_OUT_W-1:0]    window_count;
    logic                      overflow;

    modport source (output valid, estimate, estimate_valid, window_count, overflow,
                    input ready);
    modport sink   (input valid, estimate, estimate_valid, window_count, overflow,
                    output ready);
endinterface

interface wle_cfg_if
    import wle_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/wle_cell.sv
// ----------------------------------------------------------------------------
// wle_cell
// one slot of the sample chain: holds a timestamped level
// ----------------------------------------------------------------------------
module wle_cell
    import wle_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  sample_t    neighbor,
    input  sample_t    load_data,
    output sample_t    held
);

    sample_t held_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            held_reg <= load_data;
        end
        else if (ctrl.take)
        begin
            held_reg <= neighbor;
        end
    end

    assign held = held_reg;

endmodule

### rtl/wle_divider.sv
// ----------------------------------------------------------------------------
// wle_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wle_divider #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};
    assign fits      = ~diff[DIVISOR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/windowed_level_estimator_top.sv
// ----------------------------------------------------------------------------
// windowed_level_estimator_top
// sliding time window estimator over timestamped q8.8 level samples
// ----------------------------------------------------------------------------
// Samples live in a chain of RING_DEPTH cells, oldest in cell 0, held ones
// in cells 0 to count-1. Each item gives one result, and only one item at a
// time is in work. An item goes through these steps in order: accept; for
// an item with a sample, a pre-add expiry pass (minimum and average mode
// only) and the add step; a post-add expiry pass; then in minimum mode the
// whole chain is rotated once past cell 0 to find the least level, or in
// average mode a bit-serial divider runs (SUM_W = 17 + log2(RING_DEPTH));
// and the result is handed to the output register. The next item is taken
// while a finished result still waits in the output register. Expiry drops
// samples by shifting the chain down one cell per cycle; a full ring drops
// its oldest sample in the same shift that stores the new one. Registers are
// to be written only while the block is idle; the block does not enforce
// this, and cfg.ready is always high.
// ----------------------------------------------------------------------------
module windowed_level_estimator_top
    import wle_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    wle_in_if.sink    req,
    wle_out_if.source rsp,
    wle_cfg_if.sink   cfg
);

    localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int COUNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W   = LEVEL_W + IDX_W + 1;

    // control state
    state_t                    state_reg, state_next;
    logic [MODE_W-1:0]         mode_reg;
    logic [TIME_W-1:0]         window_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [IDX_W-1:0]          step_reg;
    logic                      rsp_valid_reg;

    // item payload and working values
    logic [TIME_W-1:0]         now_reg;
    logic                      has_reg;
    logic signed [LEVEL_W-1:0] level_reg;
    logic [TIME_W-1:0]         limit_reg;
    logic                      exp_en_reg;
    logic                      evicted_reg;
    logic [TIME_W-1:0]         newest_reg;
    logic signed [LEVEL_W-1:0] res_reg;
    logic                      res_valid_reg;
    logic                      neg_reg;

    // result register
    logic signed [LEVEL_W-1:0] rsp_est_reg;
    logic                      rsp_est_valid_reg;
    logic [COUNT_OUT_W-1:0]    rsp_count_reg;
    logic                      rsp_ovf_reg;

    // datapath controls from the sequencer
    logic accept;
    logic do_drop;
    logic do_append;
    logic do_evict;
    logic do_last;
    logic do_rotate;
    logic do_skip;
    logic res_zero;
    logic res_head;
    logic div_start;
    logic rsp_load;

    logic mode_window;
    logic expire_hit;
    logic full;
    logic step_held;

    // sample chain
    sample_t    cells     [RING_DEPTH];
    cell_ctrl_t cell_ctrl [RING_DEPTH];
    sample_t    new_sample;
    sample_t    tail_in;

    logic                      div_done;
    logic [SUM_W-1:0]          div_quo;
    logic [SUM_W-1:0]          sum_abs;
    logic [SUM_W-1:0]          quo_signed;
    logic signed [SUM_W-1:0]   head_ext;
    logic signed [SUM_W-1:0]   new_ext;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    assign mode_window = (mode_reg == MODE_MIN) || (mode_reg == MODE_AVG);
    assign full        = (count_reg == COUNT_W'(RING_DEPTH));
    // oldest held sample fell out of the window
    assign expire_hit  = (count_reg != '0) && exp_en_reg && (cells[0].stamp < limit_reg);
    assign step_held   = ({1'b0, step_reg} < (IDX_W + 1)'(count_reg));

    assign new_sample.stamp = now_reg;
    assign new_sample.level = level_reg;
    assign head_ext         = SUM_W'(cells[0].level);
    assign new_ext          = SUM_W'(level_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        do_drop    = 1'b0;
        do_append  = 1'b0;
        do_evict   = 1'b0;
        do_last    = 1'b0;
        do_rotate  = 1'b0;
        do_skip    = 1'b0;
        res_zero   = 1'b0;
        res_head   = 1'b0;
        div_start  = 1'b0;
        rsp_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = req.has_sample ? ST_EXP_PRE : ST_EXP_POST;
                end
            end
            ST_EXP_PRE:
            begin
                // last mode stores without expiring first
                if (mode_window && expire_hit)
                begin
                    do_drop = 1'b1;
                end
                else
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!mode_window)
                begin
                    do_last = 1'b1;
                end
                else if ((count_reg != '0) && (newest_reg >= now_reg))
                begin
                    // not later than the newest held sample
                    do_skip = 1'b1;
                end
                else if (full)
                begin
                    do_evict = 1'b1;
                end
                else
                begin
                    do_append = 1'b1;
                end
                state_next = ST_EXP_POST;
            end
            ST_EXP_POST:
            begin
                if (expire_hit)
                begin
                    do_drop = 1'b1;
                end
                else if (count_reg == '0)
                begin
                    res_zero   = 1'b1;
                    state_next = ST_OUT;
                end
                else if (mode_reg == MODE_MIN)
                begin
                    state_next = ST_MIN;
                end
                else if (mode_reg == MODE_AVG)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    res_head   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_MIN:
            begin
                do_rotate = 1'b1;
                if (step_reg == IDX_W'(RING_DEPTH - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // last cell takes cell 0 when rotating, else the new sample on eviction
    assign tail_in = do_rotate ? cells[0] : new_sample;

    genvar k;
    generate
        for (k = 0; k < RING_DEPTH; k++)
        begin : g_chain
            // take in the upper bit, load in the lower
            assign cell_ctrl[k] = {
                do_drop || do_evict || do_rotate,
                (do_append && (count_reg[IDX_W-1:0] == IDX_W'(k))) || (do_last && (k == 0))
            };

            if (k == RING_DEPTH - 1)
            begin : g_tail
                wle_cell u_cell (
                    .clk       (clk),
                    .ctrl      (cell_ctrl[k]),
                    .neighbor  (tail_in),
                    .load_data (new_sample),
                    .held      (cells[k])
                );
            end
            else
            begin : g_body
                wle_cell u_cell (
                    .clk       (clk),
                    .ctrl      (cell_ctrl[k]),
                    .neighbor  (cells[k+1]),
                    .load_data (new_sample),
                    .held      (cells[k])
                );
            end
        end
    endgenerate

    // average: divide the magnitude, put the sign back afterwards
    assign sum_abs    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quo_signed = neg_reg ? SUM_W'(-div_quo) : div_quo;

    wle_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_abs),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_LAST;
            window_reg    <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_MODE:   mode_reg   <= cfg.data[MODE_W-1:0];
                    CFG_WINDOW: window_reg <= cfg.data[TIME_W-1:0];
                    default:    ;
                endcase
            end

            if (do_drop)
            begin
                count_reg <= count_reg - COUNT_W'(1);
                sum_reg   <= sum_reg - head_ext;
            end
            else if (do_evict)
            begin
                sum_reg <= sum_reg - head_ext + new_ext;
            end
            else if (do_append)
            begin
                count_reg <= count_reg + COUNT_W'(1);
                sum_reg   <= sum_reg + new_ext;
            end
            else if (do_last)
            begin
                count_reg <= COUNT_W'(1);
                sum_reg   <= new_ext;
            end

            if (state_reg == ST_MIN)
            begin
                step_reg <= step_reg + IDX_W'(1);
            end
            else
            begin
                step_reg <= '0;
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg     <= req.now_time;
            has_reg     <= req.has_sample;
            level_reg   <= req.sample_level;
            exp_en_reg  <= (window_reg <= req.now_time);
            limit_reg   <= req.now_time - window_reg;
            evicted_reg <= 1'b0;
        end

        if (do_evict)
        begin
            evicted_reg <= 1'b1;
        end

        if (do_append || do_evict || do_last)
        begin
            newest_reg <= now_reg;
        end

        if (res_zero)
        begin
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (res_head)
        begin
            res_reg       <= cells[0].level;
            res_valid_reg <= 1'b1;
        end
        else if (div_start)
        begin
            neg_reg       <= sum_reg[SUM_W-1];
            res_valid_reg <= 1'b1;
        end
        else if ((state_reg == ST_EXP_POST) && (state_next == ST_MIN))
        begin
            res_valid_reg <= 1'b1;
        end

        // running minimum as the chain rotates past cell 0
        if (do_rotate)
        begin
            if (step_reg == '0)
            begin
                res_reg <= cells[0].level;
            end
            else if (step_held && (cells[0].level < res_reg))
            begin
                res_reg <= cells[0].level;
            end
        end

        if ((state_reg == ST_DIV) && div_done)
        begin
            res_reg <= quo_signed[LEVEL_W-1:0];
        end

        if (rsp_load)
        begin
            rsp_est_reg       <= res_reg;
            rsp_est_valid_reg <= res_valid_reg;
            rsp_count_reg     <= COUNT_OUT_W'(count_reg);
            rsp_ovf_reg       <= evicted_reg && has_reg;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.estimate       = rsp_est_reg;
    assign rsp.estimate_valid = rsp_est_valid_reg;
    assign rsp.window_count   = rsp_count_reg;
    assign rsp.overflow       = rsp_ovf_reg;

endmodule
